// ----- rtl/xtok_pkg.sv -----
// shared types, constants and helper functions of the xml tokenizer
// no dependencies
`default_nettype none

package xtok_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int SIZE_W       = 6;
    localparam int EN_W         = 4;
    localparam int CMP_W        = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET   = 6'd32;
    localparam logic [EN_W-1:0]   ENABLE_RESET = 4'hF;

    typedef enum logic [0:0] {
        REG_MAX_SIZE = 1'b0,
        REG_EVENT_EN = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_CHAR  = 1'b0,
        OP_RESET = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        EV_TAG     = 2'd0,
        EV_ATTR    = 2'd1,
        EV_CONTENT = 2'd2,
        EV_TAGEND  = 2'd3
    } ev_kind_t;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic              report;
        ev_kind_t          kind;
        logic [LEN_W-1:0]  count;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } action_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
    endfunction

    function automatic logic [LEN_W-1:0] keep_limit(input logic [SIZE_W-1:0] size);
        logic [CMP_W-1:0] s;
        s = CMP_W'(size);
        if (s > CMP_W'(BUFFER_DEPTH))
        begin
            s = CMP_W'(BUFFER_DEPTH);
        end
        if (s < CMP_W'(2))
        begin
            return '0;
        end
        return LEN_W'(s - CMP_W'(2));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/xtok_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module xtok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/xtok_parser.sv -----
// parser state machine: tracks parse state and string length, decides
// string store writes and which event to report; uses xtok_pkg
`default_nettype none

module xtok_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         opcode,
    input  wire logic [7:0]                   char_in,
    input  wire logic [xtok_pkg::LEN_W-1:0]   limit,
    input  wire logic [xtok_pkg::EN_W-1:0]    enable,
    output xtok_pkg::action_t                 act
);

    typedef enum logic [6:0] {
        P_WAIT    = 7'b0000001,
        P_START   = 7'b0000010,
        P_NAME    = 7'b0000100,
        P_ATTR    = 7'b0001000,
        P_EMPTY   = 7'b0010000,
        P_END     = 7'b0100000,
        P_CONTENT = 7'b1000000
    } pstate_t;

    pstate_t                     state_reg, state_next;
    logic                        entry_reg, entry_next;
    logic [xtok_pkg::LEN_W-1:0]  len_reg, len_next;

    always_comb
    begin
        logic [xtok_pkg::LEN_W-1:0] len_eff;
        logic [xtok_pkg::LEN_W-1:0] add_base;
        logic                       do_add;
        logic [7:0]                 add_char;
        logic                       rep;
        xtok_pkg::ev_kind_t         rep_kind;
        logic                       sp;

        state_next = state_reg;
        entry_next = entry_reg;
        len_next   = len_reg;
        act        = '0;
        do_add     = 1'b0;
        add_char   = char_in;
        rep        = 1'b0;
        rep_kind   = xtok_pkg::EV_TAG;
        sp         = xtok_pkg::is_space(char_in);
        len_eff    = len_reg;
        add_base   = len_reg;

        if (accept)
        begin
            if (opcode == xtok_pkg::OP_RESET)
            begin
                state_next = P_WAIT;
                entry_next = 1'b1;
            end
            else
            begin
                entry_next = 1'b0;
                if (entry_reg && (state_reg != P_START) && (state_reg != P_NAME)
                    && (state_reg != P_EMPTY))
                begin
                    len_eff = '0;
                end
                len_next = len_eff;
                add_base = len_eff;

                unique case (state_reg)
                    P_START:
                    begin
                        if (char_in == xtok_pkg::CH_LT || char_in == xtok_pkg::CH_GT || sp)
                        begin
                            state_next = P_START;
                        end
                        else if (char_in == xtok_pkg::CH_SLASH)
                        begin
                            state_next = P_END;
                            entry_next = 1'b1;
                        end
                        else
                        begin
                            act.wr_en   = 1'b1;
                            act.wr_addr = '0;
                            act.wr_data = char_in;
                            len_next    = xtok_pkg::LEN_W'(1);
                            state_next  = P_NAME;
                            entry_next  = 1'b1;
                        end
                    end
                    P_NAME:
                    begin
                        if (sp || char_in == xtok_pkg::CH_SLASH || char_in == xtok_pkg::CH_GT)
                        begin
                            rep        = 1'b1;
                            rep_kind   = xtok_pkg::EV_TAG;
                            entry_next = 1'b1;
                            if (sp)
                                state_next = P_ATTR;
                            else if (char_in == xtok_pkg::CH_SLASH)
                                state_next = P_EMPTY;
                            else
                                state_next = P_CONTENT;
                        end
                        else
                        begin
                            do_add = 1'b1;
                        end
                    end
                    P_EMPTY:
                    begin
                        if (char_in == xtok_pkg::CH_GT)
                        begin
                            rep        = 1'b1;
                            rep_kind   = xtok_pkg::EV_TAGEND;
                            state_next = P_CONTENT;
                            entry_next = 1'b1;
                        end
                    end
                    P_CONTENT:
                    begin
                        if (char_in == xtok_pkg::CH_LT)
                        begin
                            rep        = 1'b1;
                            rep_kind   = xtok_pkg::EV_CONTENT;
                            state_next = P_START;
                            entry_next = 1'b1;
                        end
                        else if (!(sp && len_eff == '0))
                        begin
                            do_add = 1'b1;
                        end
                    end
                    P_ATTR:
                    begin
                        if (sp)
                        begin
                            if (len_eff != '0)
                            begin
                                rep        = 1'b1;
                                rep_kind   = xtok_pkg::EV_ATTR;
                                entry_next = 1'b1;
                            end
                        end
                        else if (char_in == xtok_pkg::CH_SLASH)
                        begin
                            rep        = 1'b1;
                            rep_kind   = xtok_pkg::EV_ATTR;
                            len_next   = '0;
                            add_base   = '0;
                            do_add     = 1'b1;
                            add_char   = xtok_pkg::CH_SPACE;
                            state_next = P_EMPTY;
                            entry_next = 1'b1;
                        end
                        else if (char_in == xtok_pkg::CH_GT)
                        begin
                            rep        = 1'b1;
                            rep_kind   = xtok_pkg::EV_ATTR;
                            state_next = P_CONTENT;
                            entry_next = 1'b1;
                        end
                        else
                        begin
                            do_add = 1'b1;
                        end
                    end
                    P_END:
                    begin
                        if (char_in == xtok_pkg::CH_LT || sp)
                        begin
                            state_next = P_END;
                        end
                        else if (char_in == xtok_pkg::CH_GT)
                        begin
                            rep        = 1'b1;
                            rep_kind   = xtok_pkg::EV_TAGEND;
                            state_next = P_CONTENT;
                            entry_next = 1'b1;
                        end
                        else
                        begin
                            do_add = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (char_in == xtok_pkg::CH_LT)
                        begin
                            state_next = P_START;
                            entry_next = 1'b1;
                        end
                        else
                        begin
                            state_next = P_WAIT;
                        end
                    end
                endcase

                if (do_add && (add_base < limit))
                begin
                    act.wr_en   = 1'b1;
                    act.wr_addr = add_base[xtok_pkg::ADDR_W-1:0];
                    act.wr_data = add_char;
                    len_next    = add_base + xtok_pkg::LEN_W'(1);
                end

                act.kind   = rep_kind;
                act.count  = len_eff;
                act.report = rep && enable[rep_kind] && (len_eff != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_WAIT;
            entry_reg <= 1'b1;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/xml_sax_event_tokenizer.sv -----
// top level of the xml event tokenizer: config registers, string store ram,
// readout sequencer and output register; uses xtok_pkg, xtok_ram, xtok_parser
`default_nettype none

// usage
// - input beats on s_*: s_tdata carries a text byte, s_tuser[0] is the opcode
//   (0 process byte, 1 return the parser to the wait-for-tag state)
// - output beats on m_*: one beat per reported byte; m_tuser is the event kind
//   (0 tag start, 1 attribute, 2 content, 3 tag end), m_tlast marks the
//   final byte of a string
// - cfg_* writes register 0 (max string size) or 1 (event enable mask);
//   cfg_ready is always high, write only while the block is idle
// - a byte that reports nothing leaves s_tready high
// - a byte that reports n bytes holds s_tready low until its readout ends:
//   each string byte takes a store read step (SQ_READ) then an output load
//   step (SQ_LOAD), set by the single read port of the string store; the
//   output register is loaded from the store in the SQ_LOAD step
// - a stalled m_tready holds the output register and freezes the readout
// - reset clears parser state, length and config to defaults; the string
//   store is not cleared, no entry is read before it is written
module xml_sax_event_tokenizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // char_in
    input  wire logic [0:0] s_tuser,   // opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // char_out
    output logic      [1:0] m_tuser,   // event_kind
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_index,
    input  wire logic [5:0] cfg_data
);

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_READ = 3'b010,
        SQ_LOAD = 3'b100
    } seq_t;

    logic [xtok_pkg::SIZE_W-1:0] size_reg;
    logic [xtok_pkg::EN_W-1:0]   enable_reg;
    seq_t                        seq_reg, seq_next;
    logic [xtok_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [xtok_pkg::ADDR_W-1:0] last_idx_reg;
    xtok_pkg::ev_kind_t          kind_reg;
    logic                        pend_wr_reg, pend_wr_next;
    logic [xtok_pkg::ADDR_W-1:0] pend_addr_reg;
    logic [7:0]                  pend_data_reg;
    logic                        out_valid_reg;
    logic [7:0]                  out_char_reg;
    logic [1:0]                  out_kind_reg;
    logic                        out_last_reg;

    logic                        in_accept;
    logic                        out_free;
    logic                        at_last;
    logic                        load_beat;
    logic [xtok_pkg::LEN_W-1:0]  limit;
    xtok_pkg::action_t           act;
    logic                        ram_wr_en;
    logic [xtok_pkg::ADDR_W-1:0] ram_wr_addr;
    logic [7:0]                  ram_wr_data;
    logic                        ram_rd_en;
    logic [7:0]                  ram_rd_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = (seq_reg == SQ_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign limit     = xtok_pkg::keep_limit(size_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign at_last   = (idx_reg == last_idx_reg);
    assign load_beat = (seq_reg == SQ_LOAD) && out_free;
    assign ram_rd_en = (seq_reg == SQ_READ);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    xtok_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .opcode  (s_tuser[0]),
        .char_in (s_tdata),
        .limit   (limit),
        .enable  (enable_reg),
        .act     (act)
    );

    xtok_ram #(
        .WIDTH (8),
        .DEPTH (xtok_pkg::BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // store write: immediate when nothing is reported, else in the final load step of the readout
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = act.wr_addr;
        ram_wr_data = act.wr_data;
        if (in_accept && !act.report)
        begin
            ram_wr_en = act.wr_en;
        end
        else if (load_beat && at_last)
        begin
            ram_wr_en   = pend_wr_reg;
            ram_wr_addr = pend_addr_reg;
            ram_wr_data = pend_data_reg;
        end
    end

    always_comb
    begin
        seq_next     = seq_reg;
        idx_next     = idx_reg;
        pend_wr_next = pend_wr_reg;
        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (in_accept && act.report)
                begin
                    seq_next     = SQ_READ;
                    idx_next     = '0;
                    pend_wr_next = act.wr_en;
                end
            end
            SQ_READ:
            begin
                seq_next = SQ_LOAD;
            end
            SQ_LOAD:
            begin
                if (load_beat)
                begin
                    if (at_last)
                    begin
                        seq_next     = SQ_IDLE;
                        pend_wr_next = 1'b0;
                    end
                    else
                    begin
                        seq_next = SQ_READ;
                        idx_next = idx_reg + xtok_pkg::ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= xtok_pkg::SIZE_RESET;
            enable_reg    <= xtok_pkg::ENABLE_RESET;
            seq_reg       <= SQ_IDLE;
            idx_reg       <= '0;
            pend_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    xtok_pkg::REG_MAX_SIZE: size_reg   <= cfg_data;
                    xtok_pkg::REG_EVENT_EN: enable_reg <= cfg_data[xtok_pkg::EN_W-1:0];
                    default:                size_reg   <= size_reg;
                endcase
            end
            seq_reg     <= seq_next;
            idx_reg     <= idx_next;
            pend_wr_reg <= pend_wr_next;
            if (load_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept && act.report)
        begin
            last_idx_reg  <= xtok_pkg::ADDR_W'(act.count - xtok_pkg::LEN_W'(1));
            kind_reg      <= act.kind;
            pend_addr_reg <= act.wr_addr;
            pend_data_reg <= act.wr_data;
        end
        if (load_beat)
        begin
            out_char_reg <= ram_rd_data;
            out_kind_reg <= kind_reg;
            out_last_reg <= at_last;
        end
    end

    a_report_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && act.report) |=> (seq_reg == SQ_READ))
        else $error("report did not start a store readout");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("store written during a readout read");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(seq_reg == SQ_LOAD))
        else $error("output beat raised outside load step");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_IDLE) |-> (idx_reg <= last_idx_reg))
        else $error("readout index past string end");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (load_beat && at_last) |=> (seq_reg == SQ_IDLE && m_tvalid && m_tlast))
        else $error("final beat did not close the burst");

endmodule

`default_nettype wire
